@@ rtl/tsg_pkg.sv @@
package tsg_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned FracBits   = 16;

  localparam int unsigned NumEdges  = 9;
  localparam int unsigned NumProd   = 18;
  localparam int unsigned EdgeWidth = CoordWidth + 1;
  localparam int unsigned AdjWidth  = 2 * EdgeWidth + 1;
  localparam int unsigned DetWidth  = EdgeWidth + AdjWidth + 2;
  localparam int unsigned MagWidth  = 2 * AdjWidth;
  localparam int unsigned CntWidth  = $clog2(AdjWidth + 1);

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [EdgeWidth-1:0]  edge_t;

  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    coord_t v3_x;
    coord_t v3_y;
    coord_t v3_z;
  } tsg_in_t;

  typedef struct packed {
    logic [1:0] row_index;
    coord_t     grad_x;
    coord_t     grad_y;
    coord_t     grad_z;
    logic       singular;
    logic       last_row;
  } tsg_out_t;

  // edge matrix, entry (r, c) at index 3*r + c
  typedef struct packed {
    edge_t [NumEdges-1:0] m;
  } edge_set_t;

  typedef struct packed {
    logic                start;
    logic                neg;
    logic [AdjWidth-1:0] a_mag;
    logic [AdjWidth-1:0] b_mag;
    logic [CntWidth-1:0] count;
  } mul_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [DetWidth-1:0] prod;
  } mul_rsp_t;

  // cofactor operand sources, two products per adjugate entry
  localparam logic [3:0] ProdSrcA [NumProd] = '{
    4'd4, 4'd5, 4'd7, 4'd8, 4'd1, 4'd2, 4'd5, 4'd3, 4'd8,
    4'd6, 4'd2, 4'd0, 4'd3, 4'd4, 4'd6, 4'd7, 4'd0, 4'd1
  };
  localparam logic [3:0] ProdSrcB [NumProd] = '{
    4'd8, 4'd7, 4'd2, 4'd1, 4'd5, 4'd4, 4'd6, 4'd8, 4'd0,
    4'd2, 4'd3, 4'd5, 4'd7, 4'd6, 4'd1, 4'd0, 4'd4, 4'd3
  };
  localparam logic [3:0] DetAdjIdx [3] = '{4'd0, 4'd3, 4'd6};

  function automatic int unsigned num_width(input int unsigned frac);
    int unsigned a;
    a = AdjWidth + 2 * frac + 1;
    return ((a > DetWidth) ? a : DetWidth) + 1;
  endfunction

endpackage

@@ rtl/tsg_front.sv @@
module tsg_front import tsg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  tsg_in_t   item_i,
  input  logic      fifo_full_i,
  output logic      fifo_push_o,
  output edge_set_t edges_o
);

  logic      valid_q;
  edge_set_t edges_q, edges_d;
  coord_t    v [4][3];

  assign v[0][0] = item_i.v0_x;
  assign v[0][1] = item_i.v0_y;
  assign v[0][2] = item_i.v0_z;
  assign v[1][0] = item_i.v1_x;
  assign v[1][1] = item_i.v1_y;
  assign v[1][2] = item_i.v1_z;
  assign v[2][0] = item_i.v2_x;
  assign v[2][1] = item_i.v2_y;
  assign v[2][2] = item_i.v2_z;
  assign v[3][0] = item_i.v3_x;
  assign v[3][1] = item_i.v3_y;
  assign v[3][2] = item_i.v3_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        edges_d.m[r*3+c] = EdgeWidth'(v[c+1][r]) - EdgeWidth'(v[0][r]);
      end
    end
  end

  assign fifo_push_o = valid_q && !fifo_full_i;
  assign full        = valid_q && fifo_full_i;
  assign edges_o     = edges_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push && !full) begin
      valid_q <= 1'b1;
    end else if (fifo_push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !full) begin
      edges_q <= edges_d;
    end
  end

endmodule

@@ rtl/tsg_fifo.sv @@
module tsg_fifo import tsg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  edge_set_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output edge_set_t data_o
);

  edge_set_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/tsg_mul.sv @@
module tsg_mul import tsg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic [MagWidth-1:0] acc_q, ash_q;
  logic [AdjWidth-1:0] b_q;
  logic [CntWidth-1:0] cnt_q;
  logic                busy_q, done_q, neg_q;

  assign rsp_o.done = done_q;
  assign rsp_o.prod = neg_q ? DetWidth'(-acc_q[DetWidth-1:0]) : acc_q[DetWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CntWidth'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == CntWidth'(1))) begin
        busy_q <= 1'b0;
      end
    end
  end

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      ash_q <= MagWidth'(req_i.a_mag);
      b_q   <= req_i.b_mag;
      cnt_q <= req_i.count;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      acc_q <= acc_q + (b_q[0] ? ash_q : '0);
      ash_q <= ash_q << 1;
      b_q   <= b_q >> 1;
      cnt_q <= cnt_q - CntWidth'(1);
    end
  end

endmodule

@@ rtl/tsg_div.sv @@
module tsg_div import tsg_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBits
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [AdjWidth-1:0]                        num_i,
  input  logic [DetWidth-1:0]                        den_i,
  input  logic                                       neg_i,
  output logic                                       done_o,
  output logic signed [num_width(FRAC_BITS):0]       quo_o
);

  localparam int unsigned NumWidth = num_width(FRAC_BITS);
  localparam int unsigned QuoWidth = NumWidth + 1;
  localparam int unsigned DcWidth  = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] n_q, q_q;
  logic [DetWidth:0]   rem_q, d_q;
  logic [DetWidth+1:0] trial;
  logic                ge;
  logic [DcWidth-1:0]  cnt_q;
  logic                busy_q, done_q, neg_q;

  assign trial  = {rem_q, n_q[NumWidth-1]};
  assign ge     = (trial >= {1'b0, d_q});
  assign done_o = done_q;
  assign quo_o  = neg_q ? -QuoWidth'(q_q) : QuoWidth'(q_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == DcWidth'(1));
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == DcWidth'(1))) begin
        busy_q <= 1'b0;
      end
    end
  end

  // restoring division, one quotient bit per cycle; the added den rounds half away
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= (NumWidth'(num_i) << (2 * FRAC_BITS + 1)) + NumWidth'(den_i);
      d_q   <= {den_i, 1'b0};
      rem_q <= '0;
      q_q   <= '0;
      cnt_q <= DcWidth'(NumWidth);
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= ge ? (DetWidth+1)'(trial - {1'b0, d_q}) : trial[DetWidth:0];
      q_q   <= {q_q[NumWidth-2:0], ge};
      n_q   <= n_q << 1;
      cnt_q <= cnt_q - DcWidth'(1);
    end
  end

endmodule

@@ rtl/tsg_back.sv @@
module tsg_back import tsg_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fifo_empty_i,
  input  edge_set_t fifo_data_i,
  output logic      fifo_pop_o,
  output logic      empty,
  input  logic      pop,
  output tsg_out_t  result_o
);

  localparam int unsigned QuoWidth = num_width(FRAC_BITS) + 1;
  localparam int unsigned SumWidth = QuoWidth + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_OPA, S_MUL, S_MWAIT, S_CHK, S_DIV, S_DWAIT,
    S_SUM1, S_SUM2, S_SUM3, S_DONE
  } state_e;

  state_e                      state_q;
  edge_t                       m_q [NumEdges];
  logic signed [AdjWidth-1:0]  adj_q [NumEdges];
  logic signed [QuoWidth-1:0]  q_q [NumEdges];
  logic signed [SumWidth-1:0]  sum_q [3];
  logic signed [DetWidth-1:0]  t1_q, det_q;
  edge_t                       opa_q;
  logic [4:0]                  step_q;
  logic [1:0]                  k_q;
  logic [3:0]                  div_idx_q;
  logic                        det_phase_q, sing_q;

  logic                        set_valid_q, set_sing_q;
  logic [1:0]                  row_q;
  coord_t                      g_q [4][3];

  mul_req_t                    mul_req;
  mul_rsp_t                    mul_rsp;
  logic signed [AdjWidth-1:0]  mul_a_ext, mul_b_ext, div_num;
  logic                        div_done;
  logic signed [QuoWidth-1:0]  div_quo;

  function automatic coord_t sat(input logic signed [SumWidth-1:0] v);
    logic fits;
    fits = (&v[SumWidth-1:CoordWidth-1]) || !(|v[SumWidth-1:CoordWidth-1]);
    if (fits) begin
      return v[CoordWidth-1:0];
    end
    return v[SumWidth-1] ? {1'b1, {(CoordWidth-1){1'b0}}} : {1'b0, {(CoordWidth-1){1'b1}}};
  endfunction

  assign mul_a_ext = AdjWidth'(opa_q);
  assign mul_b_ext = det_phase_q ? adj_q[DetAdjIdx[k_q]] : AdjWidth'(m_q[ProdSrcB[step_q]]);

  always_comb begin
    mul_req.start = (state_q == S_MUL);
    mul_req.neg   = mul_a_ext[AdjWidth-1] ^ mul_b_ext[AdjWidth-1];
    mul_req.a_mag = mul_a_ext[AdjWidth-1] ? -mul_a_ext : mul_a_ext;
    mul_req.b_mag = mul_b_ext[AdjWidth-1] ? -mul_b_ext : mul_b_ext;
    mul_req.count = det_phase_q ? CntWidth'(AdjWidth) : CntWidth'(EdgeWidth);
  end

  tsg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign div_num = adj_q[div_idx_q];

  tsg_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIV),
    .num_i   (div_num[AdjWidth-1] ? -div_num : div_num),
    .den_i   (det_q[DetWidth-1] ? -det_q : det_q),
    .neg_i   (div_num[AdjWidth-1] ^ det_q[DetWidth-1]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign fifo_pop_o = (state_q == S_IDLE) && !fifo_empty_i;
  assign empty      = !set_valid_q;

  always_comb begin
    result_o.row_index = row_q;
    result_o.grad_x    = g_q[row_q][0];
    result_o.grad_y    = g_q[row_q][1];
    result_o.grad_z    = g_q[row_q][2];
    result_o.singular  = set_sing_q;
    result_o.last_row  = (row_q == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      set_valid_q <= 1'b0;
      row_q       <= 2'd0;
    end else begin
      if (pop && set_valid_q) begin
        row_q <= row_q + 2'd1;
        if (row_q == 2'd3) begin
          set_valid_q <= 1'b0;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (!fifo_empty_i) begin
            for (int e = 0; e < NumEdges; e++) begin
              m_q[e] <= fifo_data_i.m[e];
            end
            step_q      <= '0;
            k_q         <= '0;
            det_phase_q <= 1'b0;
            det_q       <= '0;
            state_q     <= S_OPA;
          end
        end
        S_OPA: begin
          opa_q   <= det_phase_q ? m_q[4'(k_q)] : m_q[ProdSrcA[step_q]];
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_rsp.done) begin
            state_q <= S_OPA;
            if (!det_phase_q) begin
              if (!step_q[0]) begin
                t1_q <= mul_rsp.prod;
              end else begin
                adj_q[step_q[4:1]] <= AdjWidth'(t1_q - mul_rsp.prod);
              end
              if (step_q == 5'(NumProd - 1)) begin
                det_phase_q <= 1'b1;
              end else begin
                step_q <= step_q + 5'd1;
              end
            end else begin
              det_q <= det_q + mul_rsp.prod;
              if (k_q == 2'd2) begin
                state_q <= S_CHK;
              end else begin
                k_q <= k_q + 2'd1;
              end
            end
          end
        end
        S_CHK: begin
          sing_q    <= (det_q == '0);
          div_idx_q <= '0;
          state_q   <= (det_q == '0) ? S_DONE : S_DIV;
        end
        S_DIV: begin
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            q_q[div_idx_q] <= div_quo;
            if (div_idx_q == 4'(NumEdges - 1)) begin
              state_q <= S_SUM1;
            end else begin
              div_idx_q <= div_idx_q + 4'd1;
              state_q   <= S_DIV;
            end
          end
        end
        S_SUM1: begin
          for (int j = 0; j < 3; j++) begin
            sum_q[j] <= SumWidth'(q_q[j]) + SumWidth'(q_q[3+j]);
          end
          state_q <= S_SUM2;
        end
        S_SUM2: begin
          for (int j = 0; j < 3; j++) begin
            sum_q[j] <= sum_q[j] + SumWidth'(q_q[6+j]);
          end
          state_q <= S_SUM3;
        end
        S_SUM3: begin
          for (int j = 0; j < 3; j++) begin
            sum_q[j] <= -sum_q[j];
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!set_valid_q) begin
            for (int j = 0; j < 3; j++) begin
              g_q[0][j] <= sing_q ? '0 : sat(sum_q[j]);
              for (int i = 0; i < 3; i++) begin
                g_q[i+1][j] <= sing_q ? '0 : sat(SumWidth'(q_q[i*3+j]));
              end
            end
            set_sing_q  <= sing_q;
            set_valid_q <= 1'b1;
            row_q       <= 2'd0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/tet_shape_gradient_core.sv @@
// Shape-function gradient of one linear tetrahedron. Push four vertex positions (signed
// fixed point, FRAC_BITS fraction bits); pop four rows in order, row 0 to row 3, last_row
// marking the final one. A zero determinant gives zero rows with singular set. One
// element at a time is computed, using the single shift-add multiplier that forms the
// adjugate and determinant and the single restoring divider that forms the nine
// inverse entries. Three elements queue at the input while one is computed, and the next
// element is computed while the previous four rows drain.
module tet_shape_gradient_core import tsg_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  tsg_in_t  item_i,
  output logic     empty,
  input  logic     pop,
  output tsg_out_t result_o
);

  logic      fifo_push, fifo_full, fifo_pop, fifo_empty;
  edge_set_t front_edges, fifo_edges;

  tsg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .fifo_full_i (fifo_full),
    .fifo_push_o (fifo_push),
    .edges_o     (front_edges)
  );

  tsg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_edges),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (fifo_edges)
  );

  tsg_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_data_i  (fifo_edges),
    .fifo_pop_o   (fifo_pop),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o)
  );

`ifndef SYNTHESIS
  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !result_o.last_row) |=>
      (!empty && (result_o.row_index == 2'($past(result_o.row_index) + 2'd1))))
    else $error("row did not advance within an element");

  a_sing_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !result_o.last_row) |=> (result_o.singular == $past(result_o.singular)))
    else $error("singular flag changed within an element");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.singular) |->
      (result_o.grad_x == '0 && result_o.grad_y == '0 && result_o.grad_z == '0))
    else $error("singular element carries nonzero gradient");
`endif

endmodule

@@ tb/tb_tet_shape_gradient_core.sv @@
`timescale 1ns / 100ps

module tb_tet_shape_gradient_core;
  import tsg_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef coord_t coord12_t [12];

  typedef struct {
    tsg_in_t tet;
    bit      typed;
    coord12_t grad;
    bit      sing;
  } dir_row_t;

  localparam coord_t ONE  = 32'sh0001_0000;
  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam coord_t CMIN = 32'sh8000_0000;
  localparam int unsigned NumRandom = 460;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     full;
  tsg_in_t  item_i = '0;
  logic     empty;
  logic     pop = 1'b0;
  tsg_out_t result_o;

  tsg_out_t grad_rows_q [$];
  dir_row_t dir_rows [$];
  int       n_mismatch = 0;
  int       n_tets = 0;
  int       n_rows = 0;
  int       n_sing = 0;
  int       sender_idle_pct = 0;
  int       recv_stall_pct = 0;

  tet_shape_gradient_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .item_i(item_i),
    .empty(empty), .pop(pop), .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic tsg_in_t pack_tet(input coord12_t p);
    return {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8], p[9], p[10], p[11]};
  endfunction

  function automatic coord_t clamp_coord(input wide_t s);
    if (s > wide_t'(CMAX)) return CMAX;
    if (s < wide_t'(CMIN)) return CMIN;
    return coord_t'(s);
  endfunction

  function automatic wide_t inv_entry(input wide_t adj, input wide_t det);
    logic [255:0] na, nd, qm;
    na = (adj < 0) ? -adj : adj;
    nd = (det < 0) ? -det : det;
    qm = ((na << (2 * FracBits + 1)) + nd) / (nd << 1);
    return ((adj < 0) != (det < 0)) ? -wide_t'(qm) : wide_t'(qm);
  endfunction

  // gradient rows of one tetrahedron, exact then saturated
  function automatic void tet_gradient(input tsg_in_t t, output tsg_out_t rows [4]);
    coord_t v [4][3];
    wide_t  m [3][3];
    wide_t  adj [3][3];
    wide_t  q [3][3];
    wide_t  det, s;
    bit     sing;
    v = '{'{t.v0_x, t.v0_y, t.v0_z}, '{t.v1_x, t.v1_y, t.v1_z},
          '{t.v2_x, t.v2_y, t.v2_z}, '{t.v3_x, t.v3_y, t.v3_z}};
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = wide_t'(v[c+1][r]) - wide_t'(v[0][r]);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        adj[i][j] = m[(j+1)%3][(i+1)%3] * m[(j+2)%3][(i+2)%3]
                  - m[(j+1)%3][(i+2)%3] * m[(j+2)%3][(i+1)%3];
    det = 0;
    for (int k = 0; k < 3; k++) det += m[0][k] * adj[k][0];
    sing = (det == 0);
    for (int k = 0; k < 4; k++) begin
      rows[k] = '0;
      rows[k].row_index = 2'(k);
      rows[k].singular = sing;
      rows[k].last_row = (k == 3);
    end
    if (!sing) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) q[i][j] = inv_entry(adj[i][j], det);
      for (int i = 0; i < 3; i++) begin
        rows[i+1].grad_x = clamp_coord(q[i][0]);
        rows[i+1].grad_y = clamp_coord(q[i][1]);
        rows[i+1].grad_z = clamp_coord(q[i][2]);
      end
      s = -(q[0][0] + q[1][0] + q[2][0]); rows[0].grad_x = clamp_coord(s);
      s = -(q[0][1] + q[1][1] + q[2][1]); rows[0].grad_y = clamp_coord(s);
      s = -(q[0][2] + q[1][2] + q[2][2]); rows[0].grad_z = clamp_coord(s);
    end
  endfunction

  task automatic add_row(input coord12_t p, input bit typed, input coord12_t g, input bit sing);
    dir_row_t d;
    d.tet = pack_tet(p);
    d.typed = typed;
    d.grad = g;
    d.sing = sing;
    dir_rows.push_back(d);
  endtask

  task automatic send_tet(input dir_row_t d);
    tsg_out_t rows [4];
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    item_i <= d.tet;
    do @(posedge clk_i); while (full);
    if (d.typed) begin
      for (int k = 0; k < 4; k++) begin
        rows[k].row_index = 2'(k);
        rows[k].grad_x = d.grad[3*k];
        rows[k].grad_y = d.grad[3*k+1];
        rows[k].grad_z = d.grad[3*k+2];
        rows[k].singular = d.sing;
        rows[k].last_row = (k == 3);
      end
    end else begin
      tet_gradient(d.tet, rows);
    end
    for (int k = 0; k < 4; k++) grad_rows_q.push_back(rows[k]);
    n_tets++;
    if (rows[0].singular) n_sing++;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(8 * 65536)) - coord_t'(4 * 65536);
      2: return coord_t'($urandom_range(512)) - coord_t'(256);
      default: return $urandom_range(1) ? CMAX - coord_t'($urandom_range(3))
                                        : CMIN + coord_t'($urandom_range(3));
    endcase
  endfunction

  function automatic dir_row_t rand_tet();
    dir_row_t d;
    coord12_t p;
    coord_t   base;
    int       shape;
    shape = $urandom_range(9);
    base = rand_coord();
    for (int i = 0; i < 12; i++) p[i] = rand_coord();
    if (shape < 6) begin
      // well-formed element near a common origin with moderate edges
      for (int i = 0; i < 3; i++) begin
        p[i] = (shape < 2) ? coord_t'($urandom) : coord_t'($urandom_range(1 << 20)) - (1 << 19);
        for (int k = 1; k < 4; k++)
          p[3*k+i] = p[i] + coord_t'($urandom_range(1 << (4 + 2 * shape))) - (1 << (3 + 2 * shape));
      end
    end else if (shape == 6) begin
      // coplanar: v3 = v1 + v2 - v0
      for (int i = 0; i < 3; i++) p[9+i] = p[3+i] + p[6+i] - p[i];
    end else if (shape == 7) begin
      for (int i = 0; i < 12; i++) p[i] = base + coord_t'($urandom_range(1));
    end
    d.tet = pack_tet(p);
    d.typed = 1'b0;
    return d;
  endfunction

  always @(posedge clk_i) begin
    tsg_out_t want;
    if (pop && !empty) begin
      n_rows++;
      if (grad_rows_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected row: idx %0d grad %h %h %h sing %b last %b",
                   result_o.row_index, result_o.grad_x, result_o.grad_y,
                   result_o.grad_z, result_o.singular, result_o.last_row);
      end else begin
        want = grad_rows_q.pop_front();
        if (result_o.row_index !== want.row_index || result_o.grad_x !== want.grad_x ||
            result_o.grad_y !== want.grad_y || result_o.grad_z !== want.grad_z ||
            result_o.singular !== want.singular || result_o.last_row !== want.last_row) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("row mismatch: exp idx %0d %h %h %h s%b l%b, got idx %0d %h %h %h s%b l%b",
                     want.row_index, want.grad_x, want.grad_y, want.grad_z,
                     want.singular, want.last_row, result_o.row_index, result_o.grad_x,
                     result_o.grad_y, result_o.grad_z, result_o.singular, result_o.last_row);
        end
      end
    end
    if (rst_ni) pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    coord12_t p, g, z;
    z = '{default: '0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // unit tetrahedron: inverse is identity
    p = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    g = '{-ONE, -ONE, -ONE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    add_row(p, 1, g, 0);
    // doubled edges halve the gradient
    p = '{0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE};
    g = '{-ONE / 2, -ONE / 2, -ONE / 2, ONE / 2, 0, 0, 0, ONE / 2, 0, 0, 0, ONE / 2};
    add_row(p, 1, g, 0);
    // one-lsb edges: inverse overflows and saturates
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
    g = '{CMIN, CMIN, CMIN, CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX};
    add_row(p, 1, g, 0);
    // degenerate shapes give zero rows with singular set
    p = '{default: '0};                       add_row(p, 1, z, 1);
    p = '{default: CMAX};                     add_row(p, 1, z, 1);
    p = '{default: CMIN};                     add_row(p, 1, z, 1);
    p = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX};
    add_row(p, 1, z, 1);
    p = '{0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE, 3 * ONE};
    add_row(p, 1, z, 1);
    // extreme spans and small mixed shapes, predicted
    p = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX};
    add_row(p, 0, z, 0);
    p = '{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN};
    add_row(p, 0, z, 0);
    p = '{CMIN, 0, CMAX, 0, CMAX, CMIN, CMAX, CMIN, 0, 1, -1, 1};
    add_row(p, 0, z, 0);
    p = '{0, 0, 0, -ONE, 3, 0, 7, ONE, -5, 0, 1, -2 * ONE};
    add_row(p, 0, z, 0);
    p = '{-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, 0};
    add_row(p, 0, z, 0);
    foreach (dir_rows[i]) send_tet(dir_rows[i]);

    for (int i = 0; i < NumRandom; i++) begin
      case ((4 * i) / NumRandom)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin sender_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      send_tet(rand_tet());
    end
    push <= 1'b0;
    while (grad_rows_q.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    $display("covered %0d tetrahedra (%0d singular), %0d gradient rows checked",
             n_tets, n_sing, n_rows);
    $display("idle phases: none, sender 61%%, receiver 61%%, both 10%%");
    if (n_mismatch == 0 && grad_rows_q.size() == 0) begin
      $display("tet_shape_gradient_core regression: pass");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("tet_shape_gradient_core regression: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout after %0d tetrahedra", n_tets);
    $display("tet_shape_gradient_core regression: fail");
    $finish;
  end

endmodule
